// ----- rtl/x86sat_pkg.sv -----
package x86sat_pkg;

  // Field widths of one request and one response word.
  localparam int SEG_W    = 3;
  localparam int ADDR_W   = 64;
  localparam int BPR_W    = 4;
  localparam int REPS_W   = 16;
  localparam int KIND_W   = 2;
  localparam int LIMIT_W  = 32;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int ASZ_W    = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTECTED_MODE = 1'b0,
    CFG_ADDRESS_SIZE   = 1'b1
  } cfg_index_t;

  // Address size codes.
  localparam logic [ASZ_W-1:0] ASZ_64 = 2'd2;

  // Repetition clipping; the clipped count and the string span widths follow from it.
  localparam int MAX_REPS = 4096;
  localparam int CLIP_W   = $clog2(MAX_REPS + 1);
  localparam int SPAN_W   = CLIP_W + BPR_W;

  // Segment codes.
  localparam logic [SEG_W-1:0] SEG_FS   = 3'd4;
  localparam logic [SEG_W-1:0] SEG_GS   = 3'd5;
  localparam logic [SEG_W-1:0] SEG_NONE = 3'd6;

  // Access kinds.
  localparam logic [KIND_W-1:0] ACC_READ  = 2'd2;
  localparam logic [KIND_W-1:0] ACC_WRITE = 2'd3;

  // Descriptor type nibble masks and patterns.
  localparam logic [TYPE_W-1:0] TYPE_RW_MASK    = 4'hA;
  localparam logic [TYPE_W-1:0] TYPE_EXEC_ONLY  = 4'h8;
  localparam logic [TYPE_W-1:0] TYPE_WRITABLE   = 4'h2;
  localparam logic [TYPE_W-1:0] TYPE_DIR_MASK   = 4'hC;
  localparam logic [TYPE_W-1:0] TYPE_EXPAND_DN  = 4'h4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OKAY   = 2'd0,
    ST_STRING = 2'd1,
    ST_GP     = 2'd2
  } status_t;

  // Per-word control flags that travel down the pipeline.
  typedef struct packed {
    logic none;         // no segment: offset passes through
    logic fsgs;         // FS or GS, base applies in 64-bit mode
    logic prot;         // protected mode
    logic long64;       // protected 64-bit mode
    logic is64;         // address size is 64-bit
    logic rights_fault; // read or write not allowed by the type
    logic expand;       // expand-down data segment
    logic big;          // default size bit
    logic single;       // clipped count is exactly one
  } ctl_t;

endpackage

// ----- rtl/x86sat_if.sv -----
// Request channel: one memory access to translate.
interface x86sat_req_if import x86sat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEG_W-1:0]    segment;
  logic [ADDR_W-1:0]   offset;
  logic [BPR_W-1:0]    rep_size;
  logic [REPS_W-1:0]   reps;
  logic [KIND_W-1:0]   access_kind;
  logic                direction_down;
  logic [ADDR_W-1:0]   seg_base;
  logic [LIMIT_W-1:0]  seg_limit;
  logic [TYPE_W-1:0]   seg_type;
  logic                seg_big;

  modport source (
    output valid, segment, offset, rep_size, reps, access_kind, direction_down,
           seg_base, seg_limit, seg_type, seg_big,
    input  ready
  );
  modport sink (
    input  valid, segment, offset, rep_size, reps, access_kind, direction_down,
           seg_base, seg_limit, seg_type, seg_big,
    output ready
  );
endinterface

// Response channel: status and linear address of one access.
interface x86sat_rsp_if import x86sat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   linear_address;
  logic [REPS_W-1:0]   reps_used;

  modport source (
    output valid, status, linear_address, reps_used,
    input  ready
  );
  modport sink (
    input  valid, status, linear_address, reps_used,
    output ready
  );
endinterface

// ----- rtl/x86_segment_address_translate.sv -----
// Segmented address translation with a four-stage pipeline. One request word
// is taken every cycle unless a full pipeline stalls, and its response is held
// in the output register until it is taken; a stall at the response side backs
// up stage by stage, so the request side keeps moving while any stage is
// empty. Stage one clips the repeat count and forms the string span with a
// small multiplier, stage two moves a backward string to its lowest byte,
// stage three adds the segment base and finds the last byte, and stage four
// runs the rights, limit and canonical checks and adds the string span back.
// The two configuration registers are read at stage one and must only be
// written while the pipeline is empty.
module x86_segment_address_translate import x86sat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  x86sat_req_if.sink            req,
  x86sat_rsp_if.source          rsp
);

  // Configuration registers.
  logic             protected_mode;
  logic [ASZ_W-1:0] address_size_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      protected_mode    <= 1'b0;
      address_size_mode <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTECTED_MODE: protected_mode    <= cfg_data[0];
        CFG_ADDRESS_SIZE:   address_size_mode <= cfg_data[ASZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and per-stage load enables.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || rsp.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= req.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage one: clip the count, form the span and the control flags.
  logic [CLIP_W-1:0] reps_clip;
  logic              none_in;
  logic              back_en;
  logic [SPAN_W-1:0] back_in;
  logic [SPAN_W-1:0] nbytes_in;
  ctl_t              ctl_in;

  always_comb begin
    none_in   = (req.segment >= SEG_NONE);
    reps_clip = (req.reps > REPS_W'(MAX_REPS)) ? CLIP_W'(MAX_REPS)
                                               : req.reps[CLIP_W-1:0];
    back_en   = !none_in && req.direction_down && (reps_clip > CLIP_W'(1));
    back_in   = back_en ? SPAN_W'(reps_clip - CLIP_W'(1)) * SPAN_W'(req.rep_size)
                        : '0;
    nbytes_in = SPAN_W'(reps_clip) * SPAN_W'(req.rep_size);

    ctl_in.none   = none_in;
    ctl_in.fsgs   = (req.segment == SEG_FS) || (req.segment == SEG_GS);
    ctl_in.prot   = protected_mode;
    ctl_in.long64 = protected_mode && (address_size_mode == ASZ_64);
    ctl_in.is64   = (address_size_mode == ASZ_64);
    ctl_in.rights_fault =
      ((req.access_kind == ACC_READ) &&
       ((req.seg_type & TYPE_RW_MASK) == TYPE_EXEC_ONLY)) ||
      ((req.access_kind == ACC_WRITE) &&
       ((req.seg_type & TYPE_RW_MASK) != TYPE_WRITABLE));
    ctl_in.expand = ((req.seg_type & TYPE_DIR_MASK) == TYPE_EXPAND_DN);
    ctl_in.big    = req.seg_big;
    ctl_in.single = (reps_clip == CLIP_W'(1));
  end

  ctl_t               ctl1, ctl2, ctl3;
  logic [ADDR_W-1:0]  off1, base1, base2;
  logic [LIMIT_W-1:0] limit1, limit2, limit3;
  logic [SPAN_W-1:0]  back1, back2, back3;
  logic [SPAN_W-1:0]  nbytes1, nbytes2;
  logic [REPS_W-1:0]  reps1, reps2, reps3;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ctl1    <= ctl_in;
      off1    <= req.offset;
      base1   <= req.seg_base;
      limit1  <= req.seg_limit;
      back1   <= back_in;
      nbytes1 <= nbytes_in;
      reps1   <= none_in ? req.reps : REPS_W'(reps_clip);
    end
  end

  // Stage two: a backward string starts at its lowest byte.
  logic [ADDR_W-1:0] start2, start3;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ctl2    <= ctl1;
      start2  <= off1 - ADDR_W'(back1);
      base2   <= base1;
      limit2  <= limit1;
      back2   <= back1;
      nbytes2 <= nbytes1;
      reps2   <= reps1;
    end
  end

  // Stage three: add the base and find the last byte of the span.
  logic [ADDR_W-1:0]  sum3;
  logic [LIMIT_W-1:0] last3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ctl3   <= ctl2;
      start3 <= start2;
      sum3   <= start2 + base2;
      last3  <= start2[LIMIT_W-1:0] + LIMIT_W'(nbytes2) - LIMIT_W'(1);
      limit3 <= limit2;
      back3  <= back2;
      reps3  <= reps2;
    end
  end

  // Stage four: checks and the final address.
  logic               hi_zero;
  logic [LIMIT_W-1:0] last_m;
  logic               wrap;
  logic               lim_fault;
  logic               prot_fault;
  logic [ADDR_W-1:0]  addr_l;
  logic               canon;
  logic               fault;
  logic [ADDR_W-1:0]  lin_base;
  logic [ADDR_W-1:0]  lin_sum;
  logic [ADDR_W-1:0]  lin_next;
  status_t            status_next;

  always_comb begin
    hi_zero = (start3[ADDR_W-1:LIMIT_W] == '0);
    last_m  = (ctl3.expand && !ctl3.big) ? {16'h0000, last3[15:0]} : last3;
    wrap    = !hi_zero || (last_m < start3[LIMIT_W-1:0]);
    if (ctl3.expand) begin
      lim_fault = (hi_zero && (start3[LIMIT_W-1:0] <= limit3)) || wrap;
    end else begin
      lim_fault = (last_m > limit3) || wrap;
    end
    prot_fault = ctl3.rights_fault || lim_fault;

    // In 64-bit mode only FS and GS carry a base.
    addr_l = ctl3.fsgs ? sum3 : start3;
    canon  = (addr_l[ADDR_W-1:47] == '0) || (addr_l[ADDR_W-1:47] == '1);

    fault = !ctl3.none && ctl3.prot && (ctl3.long64 ? !canon : prot_fault);

    lin_base = ctl3.long64 ? addr_l : {32'h0, sum3[LIMIT_W-1:0]};
    lin_sum  = lin_base + ADDR_W'(back3);

    if (ctl3.none) begin
      lin_next    = start3;
      status_next = ST_OKAY;
    end else if (fault) begin
      lin_next    = '0;
      status_next = ctl3.single ? ST_GP : ST_STRING;
    end else begin
      lin_next    = ctl3.is64 ? lin_sum : {32'h0, lin_sum[LIMIT_W-1:0]};
      status_next = ST_OKAY;
    end
  end

  logic [STATUS_W-1:0] status4;
  logic [ADDR_W-1:0]   lin4;
  logic [REPS_W-1:0]   reps4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      status4 <= status_next;
      lin4    <= lin_next;
      reps4   <= reps3;
    end
  end

  assign rsp.valid          = v4;
  assign rsp.status         = status4;
  assign rsp.linear_address = lin4;
  assign rsp.reps_used      = reps4;

`ifndef NO_ASSERTIONS
  // A faulting access reports no address.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OKAY) |-> (rsp.linear_address == '0))
    else $error("fault response carries an address");

  // A protection fault is only given to a single repetition.
  a_gp_single: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_GP) |-> (rsp.reps_used == REPS_W'(1)))
    else $error("protection fault on a string access");

  // An accepted word occupies the first stage on the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v1)
    else $error("accepted word lost at stage one");

  // A held response keeps the pipeline behind it from overwriting it.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !rsp.ready |=> v4 && $stable(lin4) && $stable(status4))
    else $error("stalled response changed");
`endif

endmodule
